/* rtl/sts_pkg.sv */
// Shared types, character codes and helper functions of the s-expression token scanner.
package sts_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int LINE_BITS   = 16;
    localparam int FIELD_BITS  = 16;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS    = $clog2(FIFO_DEPTH + 1);

    typedef logic [OFFSET_BITS-1:0] off_t;
    typedef logic [LINE_BITS-1:0]   line_t;
    typedef logic [FIELD_BITS-1:0]  field_t;

    localparam off_t  OFF_MAX  = '1;
    localparam line_t LINE_MAX = '1;

    typedef enum logic [3:0] {
        KIND_LPAREN  = 4'd0,
        KIND_RPAREN  = 4'd1,
        KIND_LSQUARE = 4'd2,
        KIND_RSQUARE = 4'd3,
        KIND_COMMENT = 4'd4,
        KIND_STRING  = 4'd5,
        KIND_SYMBOL  = 4'd6,
        KIND_NUMBER  = 4'd7,
        KIND_IDENT   = 4'd8,
        KIND_BOOLEAN = 4'd9,
        KIND_END     = 4'd10
    } kind_t;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_UPPER_T = 8'h54;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;

    localparam logic [1:0] TF_NONE = 2'd0;
    localparam logic [1:0] TF_T    = 2'd1;
    localparam logic [1:0] TF_F    = 2'd2;

    typedef struct packed {
        kind_t  kind;
        field_t tok_start;
        field_t tok_end;
        field_t tok_line;
        logic   last_of_run;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_wordstart(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'd33:8'd47],
                         [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]};
    endfunction

    function automatic logic is_break(input logic [7:0] c);
        return c inside {CH_SPACE, CH_NL, CH_TAB, CH_LPAREN, CH_RPAREN,
                         CH_LSQUARE, CH_RSQUARE, CH_SEMI, CH_NUL};
    endfunction

    function automatic off_t sat_inc(input off_t v);
        return (v == OFF_MAX) ? v : v + off_t'(1);
    endfunction

    function automatic field_t to_field(input off_t v);
        logic [31:0] wide;
        wide = 32'(v);
        return wide[FIELD_BITS-1:0];
    endfunction

    function automatic token_t make_tok(input kind_t k, input off_t s, input off_t e,
                                        input line_t ln);
        token_t t;
        t.kind        = k;
        t.tok_start   = to_field(s);
        t.tok_end     = to_field(e);
        t.tok_line    = 16'(ln);
        t.last_of_run = 1'b0;
        return t;
    endfunction

endpackage

/* rtl/sts_if.sv */
// Valid/ready stream interfaces for source bytes and for token results.
interface sts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

interface sts_token_if import sts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [3:0]            token_kind;
    logic [FIELD_BITS-1:0] token_start;
    logic [FIELD_BITS-1:0] token_end;
    logic [FIELD_BITS-1:0] token_line;
    logic                  last_of_run;

    modport source (output valid, output token_kind, output token_start, output token_end,
                    output token_line, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input token_start, input token_end,
                  input token_line, input last_of_run, output ready);
endinterface

/* rtl/sts_scan_core.sv */
// Scanner state registers and per-byte classification producing up to two tokens.
module sts_scan_core import sts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] text_byte,
    output push_t      push
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_DELIM,
        MODE_WORD,
        MODE_MINUS
    } mode_t;

    mode_t      mode_reg, mode_next;
    kind_t      kind_reg, kind_next;
    off_t       start_reg, start_next;
    line_t      line_reg, line_next;
    logic [7:0] close_reg, close_next;
    logic       digit_reg, digit_next;
    logic [1:0] tf_reg, tf_next;
    off_t       off_reg, off_next;
    line_t      lcnt_reg, lcnt_next;

    // outcome of scanning the byte with no token open
    logic       idle_emit;
    token_t     idle_tok;
    logic       idle_open;
    mode_t      idle_mode;
    kind_t      idle_kind;
    off_t       idle_start;
    logic [7:0] idle_close;
    logic [1:0] idle_tf;

    logic       close_emit;
    token_t     close_tok;
    logic       use_idle;
    kind_t      word_kind;
    token_t     r0, r1;
    logic [1:0] cnt;

    always_comb
    begin
        idle_emit  = 1'b0;
        idle_tok   = make_tok(KIND_END, off_reg, off_reg, lcnt_reg);
        idle_open  = 1'b0;
        idle_mode  = MODE_IDLE;
        idle_kind  = KIND_NUMBER;
        idle_start = off_reg;
        idle_close = CH_NUL;
        idle_tf    = TF_NONE;
        case (text_byte)
            CH_LPAREN:
            begin
                idle_emit = 1'b1;
                idle_tok  = make_tok(KIND_LPAREN, off_reg, sat_inc(off_reg), lcnt_reg);
            end
            CH_RPAREN:
            begin
                idle_emit = 1'b1;
                idle_tok  = make_tok(KIND_RPAREN, off_reg, sat_inc(off_reg), lcnt_reg);
            end
            CH_LSQUARE:
            begin
                idle_emit = 1'b1;
                idle_tok  = make_tok(KIND_LSQUARE, off_reg, sat_inc(off_reg), lcnt_reg);
            end
            CH_RSQUARE:
            begin
                idle_emit = 1'b1;
                idle_tok  = make_tok(KIND_RSQUARE, off_reg, sat_inc(off_reg), lcnt_reg);
            end
            CH_SEMI:
            begin
                idle_open  = 1'b1;
                idle_mode  = MODE_DELIM;
                idle_kind  = KIND_COMMENT;
                idle_close = CH_NL;
            end
            CH_DQUOTE:
            begin
                idle_open  = 1'b1;
                idle_mode  = MODE_DELIM;
                idle_kind  = KIND_STRING;
                idle_start = sat_inc(off_reg);
                idle_close = CH_DQUOTE;
            end
            CH_QUOTE:
            begin
                idle_open  = 1'b1;
                idle_mode  = MODE_DELIM;
                idle_kind  = KIND_SYMBOL;
                idle_start = sat_inc(off_reg);
                idle_close = CH_QUOTE;
            end
            CH_MINUS:
            begin
                idle_open = 1'b1;
                idle_mode = MODE_MINUS;
            end
            CH_NUL:
            begin
                idle_emit = 1'b1;
            end
            default:
            begin
                if (is_digit(text_byte))
                begin
                    idle_open = 1'b1;
                    idle_mode = MODE_WORD;
                end
                else if (is_wordstart(text_byte))
                begin
                    idle_open = 1'b1;
                    idle_mode = MODE_WORD;
                    idle_kind = KIND_IDENT;
                    if (text_byte == CH_UPPER_T)
                        idle_tf = TF_T;
                    else if (text_byte == CH_UPPER_F)
                        idle_tf = TF_F;
                end
            end
        endcase
    end

    assign word_kind = (kind_reg == KIND_IDENT && tf_reg != TF_NONE) ? KIND_BOOLEAN : kind_reg;

    always_comb
    begin
        mode_next  = mode_reg;
        kind_next  = kind_reg;
        start_next = start_reg;
        line_next  = line_reg;
        close_next = close_reg;
        digit_next = digit_reg;
        tf_next    = tf_reg;
        close_emit = 1'b0;
        close_tok  = make_tok(kind_reg, start_reg, off_reg, line_reg);
        use_idle   = 1'b0;

        case (mode_reg)
            MODE_DELIM:
            begin
                if (text_byte == close_reg)
                begin
                    mode_next  = MODE_IDLE;
                    close_emit = 1'b1;
                end
                else if (text_byte == CH_NUL)
                begin
                    close_emit = 1'b1;
                    use_idle   = 1'b1;
                end
            end
            MODE_WORD:
            begin
                if (is_break(text_byte))
                begin
                    close_emit     = 1'b1;
                    close_tok.kind = word_kind;
                    use_idle       = 1'b1;
                end
                else
                begin
                    tf_next = TF_NONE;
                end
            end
            MODE_MINUS:
            begin
                if (is_digit(text_byte))
                begin
                    digit_next = 1'b1;
                end
                else if (digit_reg)
                begin
                    close_emit = 1'b1;
                    use_idle   = 1'b1;
                end
                else if (is_break(text_byte))
                begin
                    // lone minus ended right away: an identifier
                    close_emit     = 1'b1;
                    close_tok.kind = KIND_IDENT;
                    use_idle       = 1'b1;
                end
                else
                begin
                    mode_next = MODE_WORD;
                    kind_next = KIND_IDENT;
                    tf_next   = TF_NONE;
                end
            end
            default:
            begin
                use_idle = 1'b1;
            end
        endcase

        if (use_idle)
        begin
            if (idle_open)
            begin
                mode_next  = idle_mode;
                kind_next  = idle_kind;
                start_next = idle_start;
                line_next  = lcnt_reg;
                close_next = idle_close;
                digit_next = 1'b0;
                tf_next    = idle_tf;
            end
            else
            begin
                mode_next = MODE_IDLE;
            end
        end

        if (text_byte == CH_NUL)
        begin
            mode_next = MODE_IDLE;
            off_next  = '0;
            lcnt_next = '0;
        end
        else
        begin
            off_next  = sat_inc(off_reg);
            lcnt_next = (text_byte == CH_NL && lcnt_reg != LINE_MAX)
                        ? lcnt_reg + line_t'(1) : lcnt_reg;
        end
    end

    always_comb
    begin
        r0  = idle_tok;
        r1  = idle_tok;
        cnt = 2'd0;
        if (close_emit)
        begin
            r0  = close_tok;
            cnt = (use_idle && idle_emit) ? 2'd2 : 2'd1;
        end
        else if (use_idle && idle_emit)
        begin
            cnt = 2'd1;
        end
        if (cnt == 2'd2)
            r1.last_of_run = 1'b1;
        else
            r0.last_of_run = 1'b1;

        push.count  = accept ? cnt : 2'd0;
        push.first  = r0;
        push.second = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            kind_reg  <= KIND_LPAREN;
            start_reg <= '0;
            line_reg  <= '0;
            close_reg <= CH_NUL;
            digit_reg <= 1'b0;
            tf_reg    <= TF_NONE;
            off_reg   <= '0;
            lcnt_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            kind_reg  <= kind_next;
            start_reg <= start_next;
            line_reg  <= line_next;
            close_reg <= close_next;
            digit_reg <= digit_next;
            tf_reg    <= tf_next;
            off_reg   <= off_next;
            lcnt_reg  <= lcnt_next;
        end
    end

endmodule

/* rtl/sts_result_fifo.sv */
// Four-entry result queue taking up to two tokens per cycle and handing out one.
module sts_result_fifo import sts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  push_t        push,
    output logic         space,
    sts_token_if.source  token
);

    token_t                mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  pop;
    token_t                head;

    assign space = count_reg <= CNT_BITS'(FIFO_DEPTH - 2);
    assign pop   = token.valid && token.ready;
    assign head  = mem[rd_ptr_reg];

    assign token.valid       = count_reg != '0;
    assign token.token_kind  = head.kind;
    assign token.token_start = head.tok_start;
    assign token.token_end   = head.tok_end;
    assign token.token_line  = head.tok_line;
    assign token.last_of_run = head.last_of_run;

    assign wr_ptr_next = wr_ptr_reg + PTR_BITS'(push.count);
    assign rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
    assign count_next  = count_reg + CNT_BITS'(push.count) - CNT_BITS'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_reg + PTR_BITS'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/sexpr_token_scanner_unit.sv */
// Top level of the s-expression token scanner.
// Usage:
//   text  : sink channel, one source byte per transaction; a zero byte ends the
//           text and resets the offset and line counters afterwards.
//   token : source channel, one token per transaction (kind, start, end, line,
//           last_of_run marking the final token caused by one byte).
// Ordering: a token caused by a byte is written into the result queue when the
//   byte is taken and offered from there; a second follows once the first is taken.
// Throughput: one byte per cycle while the token side keeps up; a byte that
//   closes a word or number on a bracket or end byte, or a string, symbol or
//   comment on the end byte, makes two tokens, taken one per transaction. The
//   rate is set by the single token read port of the four-entry result queue.
// Stalls: text.ready is high while the queue has room for two tokens, so bytes
//   keep flowing while up to two finished tokens wait; a longer token-side
//   stall drops text.ready until entries are taken.
// Reset: rst_n clears the scanner state and empties the queue; no token is
//   offered, but text.ready stays high, so a byte offered during reset is lost.
module sexpr_token_scanner_unit import sts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sts_byte_if.sink    text,
    sts_token_if.source token
);

    logic  space;
    logic  accept;
    push_t push;

    assign text.ready = space;
    assign accept     = text.valid && space;

    sts_scan_core u_scan_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (text.text_byte),
        .push      (push)
    );

    sts_result_fifo u_result_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .space (space),
        .token (token)
    );

endmodule

/* rtl/sts_checker.sv */
// Port-level assertions for the token scanner and their bind to the top level.
module sts_checker import sts_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [3:0]            token_kind,
    input logic [FIELD_BITS-1:0] token_start,
    input logic [FIELD_BITS-1:0] token_end,
    input logic                  last_of_run
);

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_kind <= KIND_END)
        else $error("token kind out of range");

    a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == KIND_END |-> token_start == token_end)
        else $error("end marker with nonzero length");

    a_bracket_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind <= KIND_RSQUARE
        |-> token_end == token_start + 16'd1 || token_end == token_start)
        else $error("bracket token length wrong");

    a_run_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("second token of a byte missing");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind)
            && $stable(token_start) && $stable(token_end) && $stable(last_of_run))
        else $error("stalled token changed");

endmodule

bind sexpr_token_scanner_unit sts_checker u_sts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (token.valid),
    .out_ready   (token.ready),
    .token_kind  (token.token_kind),
    .token_start (token.token_start),
    .token_end   (token.token_end),
    .last_of_run (token.last_of_run)
);

/* tb/sv/testbench.sv */
// Self-checking testbench of the token scanner: byte stimulus, token predictor and scoreboard.
module testbench;
    import sts_pkg::*;

    localparam longint CYCLE_LIMIT = 1000000;
    localparam int     HOLD_CYCLES = 40;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_DELIM, SCAN_WORD, SCAN_MINUS} scan_mode_t;

    class token_scoreboard;
        token_t      expected_q[$];
        scan_mode_t  mode;
        kind_t       open_kind;
        off_t        open_start;
        line_t       open_line;
        logic [7:0]  close_char;
        logic        seen_digit;
        logic [1:0]  tf;
        off_t        offset;
        line_t       line_count;
        int unsigned mismatches;

        function new();
            mode       = SCAN_IDLE;
            open_kind  = KIND_LPAREN;
            open_start = '0;
            open_line  = '0;
            close_char = CH_NUL;
            seen_digit = 1'b0;
            tf         = TF_NONE;
            offset     = '0;
            line_count = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function off_t bump(off_t v);
            return (v == OFF_MAX) ? v : v + off_t'(1);
        endfunction

        function bit digit(logic [7:0] c);
            return c >= 8'h30 && c <= 8'h39;
        endfunction

        function bit breaks(logic [7:0] c);
            return c == CH_SPACE || c == CH_NL || c == CH_TAB || c == CH_LPAREN ||
                   c == CH_RPAREN || c == CH_LSQUARE || c == CH_RSQUARE ||
                   c == CH_SEMI || c == CH_NUL;
        endfunction

        function void push_token(kind_t k, off_t s, off_t e, line_t ln);
            token_t t;
            t.kind        = k;
            t.tok_start   = s;
            t.tok_end     = e;
            t.tok_line    = ln;
            t.last_of_run = 1'b0;
            expected_q.push_back(t);
        endfunction

        function void open_token(scan_mode_t m, kind_t k, off_t s, logic [7:0] cl);
            mode       = m;
            open_kind  = k;
            open_start = s;
            open_line  = line_count;
            close_char = cl;
            seen_digit = 1'b0;
            tf         = TF_NONE;
        endfunction

        function void close_word();
            kind_t k;
            k = open_kind;
            if (k == KIND_IDENT && tf != TF_NONE)
                k = KIND_BOOLEAN;
            mode = SCAN_IDLE;
            push_token(k, open_start, offset, open_line);
        endfunction

        function void scan_free(logic [7:0] c);
            case (c)
                CH_LPAREN:  push_token(KIND_LPAREN, offset, bump(offset), line_count);
                CH_RPAREN:  push_token(KIND_RPAREN, offset, bump(offset), line_count);
                CH_LSQUARE: push_token(KIND_LSQUARE, offset, bump(offset), line_count);
                CH_RSQUARE: push_token(KIND_RSQUARE, offset, bump(offset), line_count);
                CH_SEMI:    open_token(SCAN_DELIM, KIND_COMMENT, offset, CH_NL);
                CH_DQUOTE:  open_token(SCAN_DELIM, KIND_STRING, bump(offset), CH_DQUOTE);
                CH_QUOTE:   open_token(SCAN_DELIM, KIND_SYMBOL, bump(offset), CH_QUOTE);
                CH_MINUS:   open_token(SCAN_MINUS, KIND_NUMBER, offset, CH_NUL);
                CH_NUL:     push_token(KIND_END, offset, offset, line_count);
                default:
                begin
                    if (digit(c))
                        open_token(SCAN_WORD, KIND_NUMBER, offset, CH_NUL);
                    else if (c >= 8'd33 && c <= 8'd126)
                    begin
                        open_token(SCAN_WORD, KIND_IDENT, offset, CH_NUL);
                        tf = (c == CH_UPPER_T) ? TF_T : (c == CH_UPPER_F) ? TF_F : TF_NONE;
                    end
                end
            endcase
        endfunction

        function void scan_word_byte(logic [7:0] c);
            if (breaks(c))
            begin
                close_word();
                scan_free(c);
            end
            else
                tf = TF_NONE;
        endfunction

        function void note_byte(logic [7:0] c);
            int     before_cnt;
            token_t t;
            before_cnt = expected_q.size();
            case (mode)
                SCAN_DELIM:
                begin
                    if (c == close_char)
                    begin
                        mode = SCAN_IDLE;
                        push_token(open_kind, open_start, offset, open_line);
                    end
                    else if (c == CH_NUL)
                    begin
                        mode = SCAN_IDLE;
                        push_token(open_kind, open_start, offset, open_line);
                        scan_free(c);
                    end
                end
                SCAN_WORD: scan_word_byte(c);
                SCAN_MINUS:
                begin
                    if (digit(c))
                        seen_digit = 1'b1;
                    else if (seen_digit)
                    begin
                        close_word();
                        scan_free(c);
                    end
                    else
                    begin
                        // lone minus turns into an identifier and keeps this byte
                        open_kind = KIND_IDENT;
                        mode      = SCAN_WORD;
                        tf        = TF_NONE;
                        scan_word_byte(c);
                    end
                end
                default:
                begin
                    mode = SCAN_IDLE;
                    scan_free(c);
                end
            endcase
            if (c == CH_NUL)
            begin
                mode       = SCAN_IDLE;
                offset     = '0;
                line_count = '0;
            end
            else
            begin
                offset = bump(offset);
                if (c == CH_NL && line_count != LINE_MAX)
                    line_count = line_count + line_t'(1);
            end
            if (expected_q.size() > before_cnt)
            begin
                t = expected_q.pop_back();
                t.last_of_run = 1'b1;
                expected_q.push_back(t);
            end
        endfunction

        function void report(string what, token_t want, token_t got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%s: expected kind %0d start %0d end %0d line %0d last %0d,",
                         what, want.kind, want.tok_start, want.tok_end, want.tok_line,
                         want.last_of_run);
                $display("    got kind %0d start %0d end %0d line %0d last %0d",
                         got.kind, got.tok_start, got.tok_end, got.tok_line,
                         got.last_of_run);
            end
        endfunction

        function void check_token(token_t got);
            token_t want;
            if (expected_q.size() == 0)
            begin
                want = '0;
                report("unexpected token", want, got);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                    report("token mismatch", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sts_byte_if  text_if();
    sts_token_if token_if();

    sexpr_token_scanner_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_if),
        .token (token_if)
    );

    token_scoreboard sb;
    int unsigned     idle_pct;
    int unsigned     stall_pct;
    int unsigned     bytes_sent;
    bit              hold_req;
    longint          cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        token_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                token_if.ready <= 1'b0;
            end
            else
                token_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        token_t got;
        if (rst_n && token_if.valid && token_if.ready)
        begin
            got.kind        = kind_t'(token_if.token_kind);
            got.tok_start   = token_if.token_start;
            got.tok_end     = token_if.token_end;
            got.tok_line    = token_if.token_line;
            got.last_of_run = token_if.last_of_run;
            sb.check_token(got);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            text_if.valid <= 1'b0;
            @(negedge clk);
        end
        text_if.valid     <= 1'b1;
        text_if.text_byte <= b;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_random_token();
        int         r;
        int         len;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 10)
        begin
            case ($urandom_range(3))
                0: send_byte(CH_LPAREN);
                1: send_byte(CH_RPAREN);
                2: send_byte(CH_LSQUARE);
                default: send_byte(CH_RSQUARE);
            endcase
        end
        else if (r < 30)
        begin
            if ($urandom_range(99) < 30)
                send_byte($urandom_range(1) ? CH_UPPER_T : CH_UPPER_F);
            else
                send_byte($urandom_range(1) ? 8'($urandom_range(65, 90))
                                            : 8'($urandom_range(97, 122)));
            len = $urandom_range(3);
            repeat (len)
            begin
                do
                    c = 8'($urandom_range(33, 126));
                while (c inside {CH_LPAREN, CH_RPAREN, CH_LSQUARE, CH_RSQUARE, CH_SEMI});
                send_byte(c);
            end
        end
        else if (r < 45)
        begin
            if ($urandom_range(1))
                send_byte(CH_MINUS);
            len = $urandom_range(1, 4);
            repeat (len)
                send_byte(8'($urandom_range(48, 57)));
        end
        else if (r < 50)
            send_byte(CH_MINUS);
        else if (r < 64)
        begin
            c = (r < 58) ? CH_DQUOTE : CH_QUOTE;
            send_byte(c);
            len = $urandom_range(5);
            repeat (len)
            begin
                logic [7:0] d;
                do
                    d = 8'($urandom_range(1, 255));
                while (d == c);
                send_byte(d);
            end
            if ($urandom_range(99) < 92)
                send_byte(c);
        end
        else if (r < 70)
        begin
            send_byte(CH_SEMI);
            len = $urandom_range(5);
            repeat (len)
            begin
                do
                    c = 8'($urandom_range(1, 255));
                while (c == CH_NL);
                send_byte(c);
            end
            if ($urandom_range(99) < 92)
                send_byte(CH_NL);
        end
        else if (r < 88)
        begin
            case ($urandom_range(2))
                0: send_byte(CH_SPACE);
                1: send_byte(CH_TAB);
                default: send_byte(CH_NL);
            endcase
        end
        else if (r < 96)
            send_byte(8'($urandom_range(1, 255)));
        else
            send_byte(CH_NUL);
    endtask

    initial
    begin
        logic [7:0] directed_text[$];
        int         phase;
        int unsigned target;
        sb                = new();
        idle_pct          = 0;
        stall_pct         = 0;
        bytes_sent        = 0;
        hold_req          = 1'b0;
        rst_n             = 1'b0;
        text_if.valid     = 1'b0;
        text_if.text_byte = 8'h00;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // brackets, booleans, number then letter, string, symbol, comment,
        // lone minus before a bracket, high bytes, open number at end of text
        directed_text = '{CH_LPAREN, CH_UPPER_T, CH_LSQUARE, CH_MINUS, 8'h35, 8'h78, CH_TAB,
                          CH_UPPER_F, CH_RSQUARE, CH_DQUOTE, 8'h73, CH_DQUOTE, CH_QUOTE,
                          8'h71, CH_QUOTE, CH_SEMI, 8'h63, CH_NL, CH_MINUS, CH_RPAREN,
                          8'h80, 8'hFF, 8'h31, 8'h32, CH_NUL};
        foreach (directed_text[i])
            send_byte(directed_text[i]);

        // open symbol cut by end of text
        send_byte(CH_LPAREN);
        send_byte(CH_QUOTE);
        send_byte(8'h61);
        send_byte(CH_NUL);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 48; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 48; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            target = bytes_sent + 150;
            if (phase == 0)
            begin
                repeat (30) send_random_token();
                hold_req = 1'b1;
            end
            while (bytes_sent < target)
                send_random_token();
        end

        text_if.valid <= 1'b0;
        stall_pct = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
rtl/sts_pkg.sv
rtl/sts_if.sv
rtl/sts_scan_core.sv
rtl/sts_result_fifo.sv
rtl/sexpr_token_scanner_unit.sv
rtl/sts_checker.sv
tb/sv/testbench.sv
